[rtl/core/lsv_pkg.sv]
// Shared types, constants and helper functions for the looped sample voice.
// Holds the wave memory geometry, action and register codes, the Q1.15 gain table
// and the saturation and address helpers. Depends on nothing.
package lsv_pkg;

	// Wave memory depth; a power of two, so an index wraps by dropping high bits.
	localparam int WAVE_DEPTH = 65536;
	localparam int WAVE_AW    = $clog2(WAVE_DEPTH);

	localparam int CFG_W     = 17;
	localparam int CFG_IDX_W = 3;

	localparam int VEL_MAX    = 127;
	localparam int GAIN_COUNT = 128;

	localparam logic [15:0] UNITY_Q15          = 16'h8000;
	localparam logic [15:0] RELEASE_FACTOR_RST = 16'd32758;

	// Read slots of one tick and depth of the memory read and scale pipeline.
	localparam int SLOT_COUNT = 4;
	localparam int SLOT_W     = 2;
	localparam int MEM_PIPE   = 3;

	typedef enum logic [1:0] {
		ACT_LOAD     = 2'd0,
		ACT_NOTE_ON  = 2'd1,
		ACT_NOTE_OFF = 2'd2,
		ACT_TICK     = 2'd3
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LOOP_BEGIN     = 3'd0,
		CFG_LOOP_END       = 3'd1,
		CFG_RELEASE_START  = 3'd2,
		CFG_WAVE_SAMPLES   = 3'd3,
		CFG_LOOPABLE       = 3'd4,
		CFG_STEREO         = 3'd5,
		CFG_RELEASE_FACTOR = 3'd6
	} cfg_reg_t;

	typedef enum logic [SLOT_W-1:0] {
		SLOT_A_L = 2'd0,
		SLOT_A_R = 2'd1,
		SLOT_B_L = 2'd2,
		SLOT_B_R = 2'd3
	} slot_t;

	typedef struct packed {
		logic               en;
		logic [WAVE_AW-1:0] addr;
		logic [15:0]        data;
	} wave_wr_t;

	typedef struct packed {
		logic               en;
		logic [WAVE_AW-1:0] addr;
		slot_t              slot;
	} wave_rd_t;

	typedef struct packed {
		logic               vld;
		slot_t              slot;
		logic signed [15:0] value;
	} wave_res_t;

	typedef logic [15:0] gain_table_t [GAIN_COUNT];

	// Q1.15 gain for each velocity, rounded to nearest; full velocity is exactly one.
	function automatic gain_table_t make_gain_table();
		gain_table_t t;
		for (int i = 0; i < GAIN_COUNT; i++) begin
			t[i] = 16'((i * 32768 + VEL_MAX / 2) / VEL_MAX);
		end
		return t;
	endfunction

	localparam gain_table_t GAIN_LUT = make_gain_table();

	// Sample index to memory address, wrapping modulo the memory depth.
	function automatic logic [WAVE_AW-1:0] wave_addr(input logic [16:0] idx);
		logic [WAVE_AW+16:0] wide;
		wide = {{WAVE_AW{1'b0}}, idx};
		return wide[WAVE_AW-1:0];
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
		logic signed [15:0] r;
		if (v > 20'sd32767) begin
			r = 16'sh7FFF;
		end else if (v < -20'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

[rtl/core/lsv_wave_mem.sv]
// Wave sample memory with one write port and one registered read port,
// followed by the velocity gain multiply, Q1.15 rounding and saturation.
// Depends on lsv_pkg.
module lsv_wave_mem import lsv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  wave_wr_t    wr,
	input  wave_rd_t    rd,
	input  logic [15:0] gain,
	output wave_res_t   res
);

	logic [15:0] mem [WAVE_DEPTH];

	logic [15:0]        raw_s1;
	slot_t              slot_s1;
	logic               vld_s1;
	logic signed [32:0] prod_s2;
	slot_t              slot_s2;
	logic               vld_s2;
	logic signed [15:0] value_s3;
	slot_t              slot_s3;
	logic               vld_s3;

	logic signed [32:0] raw_ext;
	logic signed [32:0] gain_ext;
	logic signed [32:0] biased;
	logic signed [32:0] shifted;

	always_comb begin
		raw_ext  = 33'($signed(raw_s1));
		gain_ext = $signed({17'b0, gain});
		biased   = prod_s2 + 33'sd16384;
		shifted  = biased >>> 15;
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			raw_s1 <= mem[rd.addr];
		end
		slot_s1  <= rd.slot;
		prod_s2  <= raw_ext * gain_ext;
		slot_s2  <= slot_s1;
		value_s3 <= sat16($signed(shifted[19:0]));
		slot_s3  <= slot_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= rd.en;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	assign res.vld   = vld_s3;
	assign res.slot  = slot_s3;
	assign res.value = value_s3;

endmodule

[rtl/core/lsv_xfade.sv]
// Release crossfade: weights the loop frame against the release frame and
// computes the decayed loop weight, with one register stage after the multiplies.
// Depends on lsv_pkg.
module lsv_xfade import lsv_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic signed [15:0] loop_l,
	input  logic signed [15:0] loop_r,
	input  logic signed [15:0] rel_l,
	input  logic signed [15:0] rel_r,
	input  logic [15:0]        weight,
	input  logic [15:0]        factor,
	output logic signed [15:0] mix_l,
	output logic signed [15:0] mix_r,
	output logic [15:0]        weight_next
);

	logic signed [34:0] diff_l;
	logic signed [34:0] diff_r;
	logic signed [34:0] weight_ext;
	logic [15:0]        factor_clamped;

	logic signed [34:0] prod_l_s1;
	logic signed [34:0] prod_r_s1;
	logic signed [15:0] rel_l_s1;
	logic signed [15:0] rel_r_s1;
	logic [31:0]        wprod_s1;

	logic signed [34:0] rnd_l;
	logic signed [34:0] rnd_r;
	logic signed [19:0] sum_l;
	logic signed [19:0] sum_r;
	logic [31:0]        wrnd;

	always_comb begin
		diff_l         = 35'(loop_l) - 35'(rel_l);
		diff_r         = 35'(loop_r) - 35'(rel_r);
		weight_ext     = $signed({19'b0, weight});
		factor_clamped = (factor > UNITY_Q15) ? UNITY_Q15 : factor;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_l_s1 <= diff_l * weight_ext;
			prod_r_s1 <= diff_r * weight_ext;
			rel_l_s1  <= rel_l;
			rel_r_s1  <= rel_r;
			wprod_s1  <= 32'(weight) * 32'(factor_clamped);
		end
	end

	always_comb begin
		rnd_l       = (prod_l_s1 + 35'sd16384) >>> 15;
		rnd_r       = (prod_r_s1 + 35'sd16384) >>> 15;
		sum_l       = 20'(rel_l_s1) + $signed(rnd_l[19:0]);
		sum_r       = 20'(rel_r_s1) + $signed(rnd_r[19:0]);
		mix_l       = sat16(sum_l);
		mix_r       = sat16(sum_r);
		wrnd        = (wprod_s1 + 32'd16384) >> 15;
		weight_next = wrnd[15:0];
	end

endmodule

[rtl/core/looped_sample_voice_with_release.sv]
// Top level of the looped sample voice: configuration registers, voice state,
// tick sequencer and output register. Depends on lsv_pkg, lsv_wave_mem and lsv_xfade.
//
// Usage. Input beats carry an action: a load writes one sample into the wave
// memory, a note-on starts playback with a gain of velocity/127, a note-off starts
// the release crossfade (loop mode only), and a tick produces one output beat with
// the left and right samples and the active flag. Loads and note beats cause no
// output and are taken one per cycle while no tick is in progress. A tick holds
// the input (in_stall high) through four reads on the single wave memory read
// port, the drain of the read, gain multiply and rounding pipeline, the crossfade
// multiply and a final step that selects the result and commits the voice state.
// The result beat appears in the output register in the cycle after that step,
// and a new tick is taken only once the previous one has finished. The output
// register is free to hold a finished beat while the next input beat is taken; if
// a new tick reaches its final step while a previous result is still stalled, it
// waits there until the receiver takes that beat. Configuration is written through
// cfg_we, cfg_index and cfg_data while the voice is idle; the user must keep to
// this, as the block itself does not enforce it. Reset clears the voice to silent
// and the registers to their defaults; the wave memory holds nothing until loaded.
module looped_sample_voice_with_release import lsv_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           action,
	input  logic [15:0]          address,
	input  logic signed [15:0]   sample_value,
	input  logic [6:0]           velocity,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [15:0]   left_sample,
	output logic signed [15:0]   right_sample,
	output logic                 active,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_READ  = 5'b00010,
		ST_DRAIN = 5'b00100,
		ST_MUL   = 5'b01000,
		ST_FIN   = 5'b10000
	} seq_state_t;

	// Configuration registers.
	logic [15:0] loop_begin_q;
	logic [15:0] loop_end_q;
	logic [15:0] release_start_q;
	logic [16:0] wave_samples_q;
	logic        loopable_q;
	logic        stereo_q;
	logic [15:0] release_factor_q;

	// Voice state.
	logic [15:0] loop_pos_q;
	logic [15:0] rel_pos_q;
	logic [15:0] weight_q;
	logic        voice_active_q;
	logic        releasing_q;
	logic [15:0] gain_q;

	// Sequencer.
	seq_state_t        state_q;
	logic [SLOT_W-1:0] step_q;
	logic [16:0]       a_data_q;
	logic [16:0]       b_data_q;
	logic              a_ok_q;
	logic              b_ok_q;
	logic signed [15:0] samp_q [SLOT_COUNT];

	// Output register.
	logic               out_valid_q;
	logic signed [15:0] left_q;
	logic signed [15:0] right_q;
	logic               active_q;

	action_t   act;
	logic      in_accept;
	logic      tick_accept;
	logic      fin_go;
	logic      fin_commit;
	wave_wr_t  wr;
	wave_rd_t  rd;
	wave_res_t wres;

	logic [15:0] a_pos;
	logic [16:0] a_data;
	logic [16:0] b_data;
	slot_t       rd_slot;
	logic [16:0] rd_index;

	logic signed [15:0] a_l;
	logic signed [15:0] a_r;
	logic signed [15:0] b_l;
	logic signed [15:0] b_r;
	logic signed [15:0] mix_l;
	logic signed [15:0] mix_r;
	logic [15:0]        weight_next;

	logic [15:0]        loop_inc;
	logic [15:0]        nxt_loop_pos;
	logic [15:0]        nxt_rel_pos;
	logic [15:0]        nxt_weight;
	logic               nxt_active;
	logic signed [15:0] res_l;
	logic signed [15:0] res_r;

	assign act         = action_t'(action);
	assign in_stall    = (state_q != ST_IDLE);
	assign in_accept   = in_valid && !in_stall;
	assign tick_accept = in_accept && (act == ACT_TICK);
	assign fin_go      = !out_valid_q || !out_stall;
	assign fin_commit  = (state_q == ST_FIN) && fin_go;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_begin_q     <= '0;
			loop_end_q       <= '0;
			release_start_q  <= '0;
			wave_samples_q   <= '0;
			loopable_q       <= 1'b0;
			stereo_q         <= 1'b1;
			release_factor_q <= RELEASE_FACTOR_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_LOOP_BEGIN:     loop_begin_q     <= cfg_data[15:0];
				CFG_LOOP_END:       loop_end_q       <= cfg_data[15:0];
				CFG_RELEASE_START:  release_start_q  <= cfg_data[15:0];
				CFG_WAVE_SAMPLES:   wave_samples_q   <= cfg_data;
				CFG_LOOPABLE:       loopable_q       <= cfg_data[0];
				CFG_STEREO:         stereo_q         <= cfg_data[0];
				CFG_RELEASE_FACTOR: release_factor_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Frame addressing. In one-shot mode the single play position lives in the
	// release position; in loop mode frame A is the loop frame and frame B the
	// release frame. A stereo frame occupies two consecutive samples.
	always_comb begin
		a_pos  = loopable_q ? loop_pos_q : rel_pos_q;
		a_data = stereo_q ? {a_pos, 1'b0} : {1'b0, a_pos};
		b_data = stereo_q ? {rel_pos_q, 1'b0} : {1'b0, rel_pos_q};
	end

	always_ff @(posedge clk) begin
		if (tick_accept) begin
			a_data_q <= a_data;
			b_data_q <= b_data;
			a_ok_q   <= (a_data < wave_samples_q);
			b_ok_q   <= (b_data < wave_samples_q);
		end
		if (wres.vld) begin
			samp_q[wres.slot] <= wres.value;
		end
	end

	// One memory read per cycle while reading: left and right of frame A, then of B.
	always_comb begin
		rd_slot = slot_t'(step_q);
		case (rd_slot)
			SLOT_A_L: rd_index = a_data_q;
			SLOT_A_R: rd_index = a_data_q + 17'd1;
			SLOT_B_L: rd_index = b_data_q;
			SLOT_B_R: rd_index = b_data_q + 17'd1;
			default:  rd_index = a_data_q;
		endcase
		rd.en   = (state_q == ST_READ);
		rd.addr = wave_addr(rd_index);
		rd.slot = rd_slot;
		wr.en   = in_accept && (act == ACT_LOAD);
		wr.addr = wave_addr({1'b0, address});
		wr.data = sample_value;
	end

	lsv_wave_mem u_wave_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.rd     (rd),
		.gain   (gain_q),
		.res    (wres)
	);

	// A mono frame is copied to both channels.
	always_comb begin
		a_l = samp_q[SLOT_A_L];
		a_r = stereo_q ? samp_q[SLOT_A_R] : samp_q[SLOT_A_L];
		b_l = samp_q[SLOT_B_L];
		b_r = stereo_q ? samp_q[SLOT_B_R] : samp_q[SLOT_B_L];
	end

	lsv_xfade u_xfade (
		.clk         (clk),
		.en          (state_q == ST_MUL),
		.loop_l      (a_l),
		.loop_r      (a_r),
		.rel_l       (b_l),
		.rel_r       (b_r),
		.weight      (weight_q),
		.factor      (release_factor_q),
		.mix_l       (mix_l),
		.mix_r       (mix_r),
		.weight_next (weight_next)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (tick_accept) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					if (step_q == SLOT_W'(SLOT_COUNT - 1)) begin
						step_q  <= '0;
						state_q <= ST_DRAIN;
					end else begin
						step_q <= step_q + SLOT_W'(1);
					end
				end
				ST_DRAIN: begin
					if (step_q == SLOT_W'(MEM_PIPE - 1)) begin
						step_q  <= '0;
						state_q <= ST_MUL;
					end else begin
						step_q <= step_q + SLOT_W'(1);
					end
				end
				ST_MUL: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result selection and next voice state for the finishing tick. The loop
	// position advances even when the release data has run out on this tick.
	always_comb begin
		loop_inc     = loop_pos_q + 16'd1;
		nxt_loop_pos = loop_pos_q;
		nxt_rel_pos  = rel_pos_q;
		nxt_weight   = weight_q;
		nxt_active   = voice_active_q;
		res_l        = '0;
		res_r        = '0;
		if (voice_active_q) begin
			if (!loopable_q) begin
				if (a_ok_q) begin
					nxt_rel_pos = rel_pos_q + 16'd1;
					res_l       = a_l;
					res_r       = a_r;
				end else begin
					nxt_active = 1'b0;
				end
			end else if (!a_ok_q) begin
				nxt_active = 1'b0;
			end else begin
				nxt_loop_pos = (loop_inc == loop_end_q) ? loop_begin_q : loop_inc;
				res_l        = a_l;
				res_r        = a_r;
				if (releasing_q) begin
					if (b_ok_q) begin
						nxt_rel_pos = rel_pos_q + 16'd1;
						nxt_weight  = weight_next;
						res_l       = mix_l;
						res_r       = mix_r;
					end else begin
						nxt_active = 1'b0;
						res_l      = '0;
						res_r      = '0;
					end
				end
			end
		end
	end

	// Voice state: note beats update it on acceptance, ticks when they finish.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_pos_q     <= '0;
			rel_pos_q      <= '0;
			weight_q       <= UNITY_Q15;
			voice_active_q <= 1'b0;
			releasing_q    <= 1'b0;
			gain_q         <= '0;
		end else if (in_accept && (act == ACT_NOTE_ON)) begin
			gain_q         <= GAIN_LUT[velocity];
			loop_pos_q     <= '0;
			rel_pos_q      <= '0;
			releasing_q    <= 1'b0;
			voice_active_q <= 1'b1;
			weight_q       <= UNITY_Q15;
		end else if (in_accept && (act == ACT_NOTE_OFF)) begin
			if (!releasing_q && loopable_q) begin
				rel_pos_q   <= release_start_q;
				releasing_q <= 1'b1;
				weight_q    <= UNITY_Q15;
			end
		end else if (fin_commit) begin
			loop_pos_q     <= nxt_loop_pos;
			rel_pos_q      <= nxt_rel_pos;
			weight_q       <= nxt_weight;
			voice_active_q <= nxt_active;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_commit) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_commit) begin
			left_q   <= res_l;
			right_q  <= res_r;
			active_q <= nxt_active;
		end
	end

	assign out_valid    = out_valid_q;
	assign left_sample  = left_q;
	assign right_sample = right_q;
	assign active       = active_q;

`ifndef SYNTHESIS
	// A finishing tick always leaves a beat in the output register.
	a_fin_loads_output: assert property (@(posedge clk) disable iff (!arst_n)
		fin_commit |=> out_valid)
		else $error("finished tick did not load the output register");

	// Scaled samples only return while the sequencer is reading or draining.
	a_mem_return_window: assert property (@(posedge clk) disable iff (!arst_n)
		wres.vld |-> ((state_q == ST_READ) || (state_q == ST_DRAIN)))
		else $error("wave memory result outside the read window");

	// The loop weight decays from unity and never grows above it.
	a_weight_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		weight_q <= UNITY_Q15)
		else $error("loop weight above unity");

	// A tick beat starts the read sequence in the next cycle.
	a_tick_starts_read: assert property (@(posedge clk) disable iff (!arst_n)
		tick_accept |=> (state_q == ST_READ) && (step_q == '0))
		else $error("tick did not start the read sequence");
`endif

endmodule

[test/looped_sample_voice_with_release_tb.sv]
// Self-checking testbench for looped_sample_voice_with_release: directed and random beats
// checked against a cycle-free model of the voice kept in this file.
// Depends on lsv_pkg and the RTL of looped_sample_voice_with_release only.
module looped_sample_voice_with_release_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lsv_pkg::*;

	localparam int HALF_PERIOD  = 6;
	localparam int RESET_CYCLES = 7;
	// Rest after the last predicted beat; it leaves room for a tick and for loads and notes.
	localparam int SETTLE       = 24;
	localparam int HOLD_LEN     = 300;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int RANDOM_BEATS = 600;

	// One output beat as the model predicts it; samples are kept as raw bit patterns.
	typedef struct packed {
		logic [15:0] left;
		logic [15:0] right;
		logic        act;
	} voice_frame_t;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 in_valid     = 1'b0;
	logic                 in_stall;
	logic [1:0]           action       = ACT_LOAD;
	logic [15:0]          address      = '0;
	logic signed [15:0]   sample_value = '0;
	logic [6:0]           velocity     = '0;
	logic                 out_valid;
	logic                 out_stall    = 1'b0;
	logic signed [15:0]   left_sample;
	logic signed [15:0]   right_sample;
	logic                 active;
	logic                 cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index    = CFG_LOOP_BEGIN;
	logic [CFG_W-1:0]     cfg_data     = '0;

	looped_sample_voice_with_release u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.address      (address),
		.sample_value (sample_value),
		.velocity     (velocity),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.left_sample  (left_sample),
		.right_sample (right_sample),
		.active       (active),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// Model copy of the configuration registers, with their reset values.
	logic [15:0] lp_begin    = '0;
	logic [15:0] lp_end      = '0;
	logic [15:0] rel_start   = '0;
	logic [16:0] n_samples   = '0;
	logic        loop_mode   = 1'b0;
	logic        stereo_mode = 1'b1;
	logic [15:0] decay       = RELEASE_FACTOR_RST;

	// Model copy of the voice state.
	logic [15:0] loop_pos   = '0;
	logic [15:0] rel_pos    = '0;
	int          xfade_w    = 32768;
	logic        playing    = 1'b0;
	logic        in_release = 1'b0;
	logic [6:0]  note_vel   = '0;

	// Shadow of the wave memory. The loaded flags keep every tick away from entries
	// that were never written, since the block gives no defined value for them.
	logic [15:0] shadow_mem [WAVE_DEPTH];
	bit          loaded     [WAVE_DEPTH];

	voice_frame_t frames_due [$];
	voice_frame_t want_frame;

	int gap_pct        = 0;
	int stall_pct      = 0;
	bit hold_armed     = 1'b0;
	int hold_count     = 0;
	int cycle_count    = 0;
	int errors         = 0;
	int beats_sent     = 0;
	int frames_checked = 0;
	int xfade_ticks    = 0;
	int setups         = 0;

	// ---------------------------------------------------------------- model arithmetic

	// Q1.15 product back to integer, rounding half up; the shift floors negatives.
	function automatic longint q15_round(longint v);
		return (v + 64'sd16384) >>> 15;
	endfunction

	function automatic int clip16(longint v);
		if (v > 32767) begin
			return 32767;
		end
		if (v < -32768) begin
			return -32768;
		end
		return int'(v);
	endfunction

	// Stored sample times the note gain, where the gain is velocity/127 rounded into Q1.15.
	function automatic int scaled_sample(int idx);
		logic signed [15:0] s;
		longint gain;
		s = shadow_mem[idx[15:0]];
		gain = (longint'(note_vel) * 32768 + 63) / 127;
		return clip16(q15_round(longint'(s) * gain));
	endfunction

	function automatic int frame_base(logic [15:0] pos);
		return stereo_mode ? 2 * int'(pos) : int'(pos);
	endfunction

	// A frame exists while its first sample index is below the sample count. The right
	// half of a stereo frame is taken from the next index even past the end, and a mono
	// sample feeds both channels.
	function automatic bit read_frame(input logic [15:0] pos, output int l, output int r);
		int base;
		base = frame_base(pos);
		l = 0;
		r = 0;
		if (base >= int'(n_samples)) begin
			return 1'b0;
		end
		l = scaled_sample(base);
		r = stereo_mode ? scaled_sample(base + 1) : l;
		return 1'b1;
	endfunction

	// First never-written index that a frame would read, or -1.
	function automatic int frame_gap(logic [15:0] pos);
		int base;
		base = frame_base(pos);
		if (base >= int'(n_samples)) begin
			return -1;
		end
		if (!loaded[base[15:0]]) begin
			return base % 65536;
		end
		if (stereo_mode && !loaded[(base + 1) % 65536]) begin
			return (base + 1) % 65536;
		end
		return -1;
	endfunction

	// First never-written index that the next tick would read, or -1. The release frame
	// is read only when the loop frame exists.
	function automatic int next_tick_gap();
		int gap;
		if (!playing) begin
			return -1;
		end
		if (!loop_mode) begin
			return frame_gap(rel_pos);
		end
		if (frame_base(loop_pos) >= int'(n_samples)) begin
			return -1;
		end
		gap = frame_gap(loop_pos);
		if (gap >= 0 || !in_release) begin
			return gap;
		end
		return frame_gap(rel_pos);
	endfunction

	// One tick of the voice: one-shot plays the release counter from the start; loop mode
	// plays the loop and, after a note-off, fades from it into the release frames.
	task automatic advance_voice();
		int ll, lr, rl, rr, out_l, out_r;
		longint decay_q;
		voice_frame_t due;
		out_l = 0;
		out_r = 0;
		if (playing) begin
			if (!loop_mode) begin
				if (read_frame(rel_pos, rl, rr)) begin
					rel_pos = rel_pos + 16'd1;
					out_l = rl;
					out_r = rr;
				end else begin
					playing = 1'b0;
				end
			end else if (!read_frame(loop_pos, ll, lr)) begin
				playing = 1'b0;
			end else begin
				loop_pos = loop_pos + 16'd1;
				if (loop_pos == lp_end) begin
					loop_pos = lp_begin;
				end
				out_l = ll;
				out_r = lr;
				if (in_release) begin
					if (read_frame(rel_pos, rl, rr)) begin
						// Factors above one decay nothing.
						decay_q = (decay > UNITY_Q15) ? 64'sd32768 : longint'(decay);
						rel_pos = rel_pos + 16'd1;
						out_l = clip16(rl + q15_round(longint'(ll - rl) * xfade_w));
						out_r = clip16(rr + q15_round(longint'(lr - rr) * xfade_w));
						xfade_w = int'(q15_round(longint'(xfade_w) * decay_q) & 64'hFFFF);
						xfade_ticks++;
					end else begin
						out_l = 0;
						out_r = 0;
						playing = 1'b0;
					end
				end
			end
		end
		due.left = out_l[15:0];
		due.right = out_r[15:0];
		due.act = playing;
		frames_due.push_back(due);
	endtask

	task automatic apply_beat(action_t act, logic [15:0] addr, logic [15:0] value,
			logic [6:0] vel);
		case (act)
			ACT_LOAD: begin
				shadow_mem[addr] = value;
				loaded[addr] = 1'b1;
			end
			ACT_NOTE_ON: begin
				note_vel = vel;
				rel_pos = '0;
				loop_pos = '0;
				in_release = 1'b0;
				playing = 1'b1;
				xfade_w = 32768;
			end
			ACT_NOTE_OFF: begin
				// Ignored in one-shot mode and while already releasing, but it arms the
				// release even on a silent voice.
				if (!in_release && loop_mode) begin
					rel_pos = rel_start;
					in_release = 1'b1;
					xfade_w = 32768;
				end
			end
			ACT_TICK: begin
				advance_voice();
			end
			default: begin
			end
		endcase
	endtask

	// ---------------------------------------------------------------- drivers

	// Writes one register. The write enable stays high so that back-to-back writes never
	// lower and raise it in the same step; the caller drops it after the last one.
	task automatic set_reg(cfg_reg_t idx, int value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(value);
		@(posedge clk);
		case (idx)
			CFG_LOOP_BEGIN:     lp_begin = value[15:0];
			CFG_LOOP_END:       lp_end = value[15:0];
			CFG_RELEASE_START:  rel_start = value[15:0];
			CFG_WAVE_SAMPLES:   n_samples = value[16:0];
			CFG_LOOPABLE:       loop_mode = value[0];
			CFG_STEREO:         stereo_mode = value[0];
			CFG_RELEASE_FACTOR: decay = value[15:0];
			default: begin
			end
		endcase
	endtask

	// The sender rests until every predicted beat has come out, then lets the last
	// loads and notes clear the block.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (frames_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic setup_voice(int b, int e, int rs, int n, bit lp, bit st, int fac);
		wait_idle();
		set_reg(CFG_LOOP_BEGIN, b);
		set_reg(CFG_LOOP_END, e);
		set_reg(CFG_RELEASE_START, rs);
		set_reg(CFG_WAVE_SAMPLES, n);
		set_reg(CFG_LOOPABLE, int'(lp));
		set_reg(CFG_STEREO, int'(st));
		set_reg(CFG_RELEASE_FACTOR, fac);
		cfg_we <= 1'b0;
		setups++;
	endtask

	// Offers one input beat, with a random run of idle cycles first, and returns at the
	// edge that takes it. Handshake signals are sampled at the falling edge, where they
	// already hold what the next rising edge will see.
	task automatic send_beat(action_t act, logic [15:0] addr, logic [15:0] value,
			logic [6:0] vel);
		bit stalled;
		if ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < gap_pct);
		end
		in_valid <= 1'b1;
		action <= act;
		address <= addr;
		sample_value <= value;
		velocity <= vel;
		do begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
		end while (stalled);
		apply_beat(act, addr, value, vel);
		beats_sent++;
	endtask

	// A tick, preceded by loads of random data into any entry it would otherwise read
	// before it was ever written.
	task automatic send_tick();
		int gap;
		gap = next_tick_gap();
		while (gap >= 0) begin
			send_beat(ACT_LOAD, gap[15:0], 16'($urandom), 7'($urandom));
			gap = next_tick_gap();
		end
		send_beat(ACT_TICK, 16'($urandom), 16'($urandom), 7'($urandom));
	endtask

	task automatic send_note_on(logic [6:0] vel);
		send_beat(ACT_NOTE_ON, 16'($urandom), 16'($urandom), vel);
	endtask

	task automatic send_note_off();
		send_beat(ACT_NOTE_OFF, 16'($urandom), 16'($urandom), 7'($urandom));
	endtask

	// Any action with random content: stray loads anywhere, notes at odd moments.
	task automatic send_noise();
		action_t act;
		act = action_t'($urandom_range(3));
		if (act == ACT_TICK) begin
			send_tick();
		end else begin
			send_beat(act, 16'($urandom), 16'($urandom), 7'($urandom));
		end
	endtask

	// ---------------------------------------------------------------- random choices

	// Loop points and the release cue: mostly small, sometimes anywhere or at the top.
	function automatic int pick_frame();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 8) begin
			return 65535;
		end
		if (r < 16) begin
			return $urandom_range(65535);
		end
		return $urandom_range(24);
	endfunction

	function automatic int pick_length();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 10) begin
			return 0;
		end
		if (r < 20) begin
			return WAVE_DEPTH;
		end
		if (r < 28) begin
			return $urandom_range(WAVE_DEPTH);
		end
		return $urandom_range(1, 48);
	endfunction

	function automatic int pick_decay();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 15) begin
			return 0;
		end
		if (r < 30) begin
			return 32768;
		end
		if (r < 35) begin
			return 65535;
		end
		if (r < 70) begin
			return $urandom_range(28000, 32767);
		end
		return $urandom_range(32768);
	endfunction

	function automatic logic [6:0] pick_velocity();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 20) begin
			return 7'd127;
		end
		if (r < 30) begin
			return 7'd0;
		end
		return 7'($urandom);
	endfunction

	// ---------------------------------------------------------------- tests

	// Straight after reset: a silent voice gives zeros, and a note on an empty one-shot
	// wave stops at the first tick. The note-off is ignored in one-shot mode.
	task automatic test_silent_voice();
		send_tick();
		send_note_on(7'd127);
		send_note_off();
		send_tick();
		send_tick();
	endtask

	// One-shot playback of full-scale samples, mono copied to both sides, then stereo with
	// an odd sample count so the last right half comes from past the end.
	task automatic test_one_shot();
		setup_voice(0, 0, 0, 3, 1'b0, 1'b0, int'(RELEASE_FACTOR_RST));
		send_beat(ACT_LOAD, 16'd0, 16'h7FFF, 7'd0);
		send_beat(ACT_LOAD, 16'd1, 16'h8000, 7'd127);
		send_beat(ACT_LOAD, 16'd2, 16'hFFFF, 7'd0);
		send_note_on(7'd127);
		repeat (4) send_tick();
		setup_voice(0, 0, 0, 3, 1'b0, 1'b1, int'(RELEASE_FACTOR_RST));
		send_note_on(7'd1);
		repeat (3) send_tick();
	endtask

	// Loop mode: a note-off on a silent voice, a short loop that wraps, a crossfade at
	// half decay, a second note-off that must be ignored, and the release running dry.
	task automatic test_loop_release();
		setup_voice(1, 3, 4, 8, 1'b1, 1'b0, 16384);
		send_note_off();
		send_note_on(7'd64);
		repeat (4) send_tick();
		send_note_off();
		repeat (2) send_tick();
		send_note_off();
		repeat (3) send_tick();
	endtask

	// Both positions cross the 16-bit wrap: the loop jumps back to the top frame, the
	// release starts there, and the oversized decay factor acts as one.
	task automatic test_position_wrap();
		setup_voice(65535, 1, 65535, WAVE_DEPTH, 1'b1, 1'b0, 65535);
		send_note_on(7'd100);
		repeat (4) send_tick();
		send_note_off();
		repeat (3) send_tick();
	endtask

	// Mode bits take effect on the next tick of a note already playing.
	task automatic test_live_mode();
		wait_idle();
		set_reg(CFG_LOOPABLE, 0);
		set_reg(CFG_STEREO, 1);
		cfg_we <= 1'b0;
		repeat (2) send_tick();
		wait_idle();
		set_reg(CFG_LOOPABLE, 1);
		set_reg(CFG_STEREO, 0);
		set_reg(CFG_RELEASE_FACTOR, 30000);
		cfg_we <= 1'b0;
		repeat (2) send_tick();
	endtask

	// The receiver holds off for a long stretch while ticks keep coming, so the output
	// register fills and the block stalls its input.
	task automatic test_backpressure();
		setup_voice(0, 4, 0, 8, 1'b1, 1'b1, 32000);
		send_note_on(7'd127);
		hold_armed = 1'b1;
		repeat (20) send_tick();
		wait_idle();
	endtask

	// Random setups, each played through a few notes: note-on, ticks, usually a note-off
	// and more ticks, with stray beats mixed in. Idling styles rotate with the setup.
	task automatic test_random_play();
		int start_beats;
		int round;
		start_beats = beats_sent;
		round = 0;
		while (beats_sent - start_beats < RANDOM_BEATS) begin
			setup_voice(pick_frame(), pick_frame(), pick_frame(), pick_length(),
				$urandom_range(9) < 7, 1'($urandom_range(1)), pick_decay());
			case (round % 4)
				0: begin
					gap_pct = 0;
					stall_pct = 0;
				end
				1: begin
					gap_pct = 86;
					stall_pct = 0;
				end
				2: begin
					gap_pct = 0;
					stall_pct = 86;
				end
				default: begin
					gap_pct = 6;
					stall_pct = 6;
				end
			endcase
			round++;
			repeat ($urandom_range(2, 4)) begin
				if ($urandom_range(3) == 0) begin
					send_noise();
				end
				send_note_on(pick_velocity());
				repeat ($urandom_range(1, 16)) send_tick();
				if ($urandom_range(3) != 0) begin
					send_note_off();
					repeat ($urandom_range(1, 24)) send_tick();
				end
				if ($urandom_range(4) == 0) begin
					repeat ($urandom_range(1, 4)) send_noise();
				end
				// Now and then the sender waits for every result before going on.
				if ($urandom_range(5) == 0) begin
					wait_idle();
				end
			end
		end
		gap_pct = 0;
		stall_pct = 0;
	endtask

	// ---------------------------------------------------------------- output side

	// Receiver stall: random at the phase's rate, or solid for the whole long hold-off.
	always @(posedge clk) begin
		if (hold_armed) begin
			out_stall <= 1'b1;
			hold_count++;
			if (hold_count >= HOLD_LEN) begin
				hold_armed = 1'b0;
				hold_count = 0;
			end
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Each output beat taken at the coming rising edge is checked against the oldest
	// predicted one.
	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			frames_checked++;
			if (frames_due.size() == 0) begin
				errors++;
				$display("%0t: output beat with no tick waiting: left %0d right %0d active %0b",
					$time, left_sample, right_sample, active);
			end else begin
				want_frame = frames_due.pop_front();
				if (left_sample !== want_frame.left) begin
					errors++;
					$display("%0t: left_sample expected %0d, got %0d", $time,
						$signed(want_frame.left), left_sample);
				end
				if (right_sample !== want_frame.right) begin
					errors++;
					$display("%0t: right_sample expected %0d, got %0d", $time,
						$signed(want_frame.right), right_sample);
				end
				if (active !== want_frame.act) begin
					errors++;
					$display("%0t: active expected %0b, got %0b", $time,
						want_frame.act, active);
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: run still busy after %0d cycles", $time, CYCLE_LIMIT);
			$display("looped_sample_voice_with_release_tb: done, errors");
			$finish;
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_silent_voice();
		test_one_shot();
		test_loop_release();
		test_position_wrap();
		test_live_mode();
		test_backpressure();
		test_random_play();
		wait_idle();
		$display("Covered %0d input beats over %0d voice setups, one-shot and loop play,",
			beats_sent, setups);
		$display("position wraps and stalls; %0d output beats checked, %0d of them crossfaded.",
			frames_checked, xfade_ticks);
		if (errors == 0) begin
			$display("looped_sample_voice_with_release_tb: done, clean");
		end else begin
			$display("looped_sample_voice_with_release_tb: done, errors");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/core/lsv_pkg.sv
rtl/core/lsv_wave_mem.sv
rtl/core/lsv_xfade.sv
rtl/core/looped_sample_voice_with_release.sv
test/looped_sample_voice_with_release_tb.sv
